>>> rtl/lsf_pkg.sv
package lsf_pkg;

   // Largest source the counters are sized for; the counters stop at the smaller
   // of this size minus one and the 24-bit field maximum.
   localparam longint unsigned MAX_SOURCE_BYTES = 64'd16777216;
   localparam int CNT_W = 24;
   localparam logic [CNT_W-1:0] CNT_CAP =
      CNT_W'(((MAX_SOURCE_BYTES - 64'd1) > 64'hFFFFFF) ? 64'hFFFFFF
                                                        : (MAX_SOURCE_BYTES - 64'd1));

   // Most results one request can cause.
   localparam int SLOTS = 3;

   // Character codes used by the splice logic and the classifier.
   localparam logic [7:0] CHAR_BSL = 8'h5C;
   localparam logic [7:0] CHAR_LF  = 8'h0A;
   localparam logic [7:0] CHAR_CR  = 8'h0D;
   localparam logic [7:0] CHAR_TAB = 8'h09;
   localparam logic [7:0] CHAR_VT  = 8'h0B;
   localparam logic [7:0] CHAR_FF  = 8'h0C;
   localparam logic [7:0] CHAR_SP  = 8'h20;
   localparam logic [7:0] CHAR_US  = 8'h5F;

   // What the splice logic holds back between requests.
   typedef enum logic [2:0] {
      PEND_NONE   = 3'b001,
      PEND_BSL    = 3'b010,
      PEND_BSL_CR = 3'b100
   } pend_type;

   // One result without its class flags.
   typedef struct packed {
      logic [7:0]       out_char;
      logic             has_char;
      logic [CNT_W-1:0] phys_offset;
      logic [CNT_W-1:0] logical_index;
      logic             end_of_run;
   } slot_type;

   // Head of the result bundle as seen by the output stage.
   typedef struct packed {
      logic     valid;
      slot_type slot;
   } head_type;

   typedef struct packed {
      logic is_space;
      logic is_digit;
      logic is_hex;
      logic is_ident_start;
      logic is_ident_cont;
   } class_type;

   // Saturating increment of a counter.
   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      logic [CNT_W-1:0] r;
      r = (v >= CNT_CAP) ? CNT_CAP : v + CNT_W'(1);
      return r;
   endfunction

   // Character classes; NUL falls in none of them.
   function automatic class_type classify(input logic [7:0] c);
      class_type r;
      logic dig;
      logic alpha;
      dig   = (c >= 8'h30) && (c <= 8'h39);
      alpha = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
              || (c == CHAR_US);
      r.is_space = (c == CHAR_SP) || (c == CHAR_TAB) || (c == CHAR_VT)
                   || (c == CHAR_FF) || (c == CHAR_CR);
      r.is_digit = dig;
      r.is_hex   = dig || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
      r.is_ident_start = alpha;
      r.is_ident_cont  = alpha || dig;
      return r;
   endfunction

endpackage

>>> rtl/line_splice_filter_with_char_class.sv
// Channel    Direction  Handshake            Payload
// req        in         req_valid/req_stall  req_in_byte, req_in_last
// rsp        out        rsp_valid/rsp_stall  char, offsets, class flags, end_of_run
//
// A request is taken in every cycle while it causes at most one result and rsp is
// not stalled; one that causes two or three results holds req_stall until the
// single result bundle register, which drains one slot per cycle while rsp is not
// stalled, gives up its last slot. Results reach rsp through the output register.
// Reset is synchronous and clears the splice state and both valid flags.
// A stall on rsp backs up into the bundle and then onto req_stall.
module line_splice_filter_with_char_class (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [7:0]                  req_in_byte,
   input  logic                        req_in_last,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [7:0]                  rsp_out_char,
   output logic                        rsp_has_char,
   output logic [lsf_pkg::CNT_W-1:0]   rsp_phys_offset,
   output logic [lsf_pkg::CNT_W-1:0]   rsp_logical_index,
   output logic                        rsp_is_space,
   output logic                        rsp_is_digit,
   output logic                        rsp_is_hex,
   output logic                        rsp_is_ident_start,
   output logic                        rsp_is_ident_cont,
   output logic                        rsp_end_of_run
);

   lsf_pkg::head_type head;
   logic              head_take;

   // Splice removal and result bundle.
   lsf_splice u_splice (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .head        (head),
      .head_take   (head_take)
   );

   // Classification and output register.
   lsf_emit u_emit (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .head_take          (head_take),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_char       (rsp_out_char),
      .rsp_has_char       (rsp_has_char),
      .rsp_phys_offset    (rsp_phys_offset),
      .rsp_logical_index  (rsp_logical_index),
      .rsp_is_space       (rsp_is_space),
      .rsp_is_digit       (rsp_is_digit),
      .rsp_is_hex         (rsp_is_hex),
      .rsp_is_ident_start (rsp_is_ident_start),
      .rsp_is_ident_cont  (rsp_is_ident_cont),
      .rsp_end_of_run     (rsp_end_of_run)
   );

endmodule

>>> rtl/lsf_splice.sv
module lsf_splice (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_in_byte,
   input  logic               req_in_last,
   output lsf_pkg::head_type  head,
   input  logic               head_take
);

   // Splice state.
   lsf_pkg::pend_type             pend_ff, pend_in;
   logic [lsf_pkg::CNT_W-1:0]     held_ff, held_in;
   logic [lsf_pkg::CNT_W-1:0]     phys_ff, phys_in;
   logic [lsf_pkg::CNT_W-1:0]     lcnt_ff, lcnt_in;

   // Result bundle of the last request; slot 0 is the head.
   lsf_pkg::slot_type             slot_ff [lsf_pkg::SLOTS];
   lsf_pkg::slot_type             slot_in [lsf_pkg::SLOTS];
   logic [1:0]                    cnt_ff;
   logic [2:0]                    cnt_in;

   logic [lsf_pkg::CNT_W-1:0]     lidx [4];
   logic [lsf_pkg::CNT_W-1:0]     held_next;
   logic                          accept;

   function automatic lsf_pkg::slot_type make_slot(input logic [7:0] c,
                                                   input logic [lsf_pkg::CNT_W-1:0] off,
                                                   input logic [lsf_pkg::CNT_W-1:0] li);
      lsf_pkg::slot_type s;
      s.out_char      = c;
      s.has_char      = 1'b1;
      s.phys_offset   = off;
      s.logical_index = li;
      s.end_of_run    = 1'b0;
      return s;
   endfunction

   // A new request is taken when the bundle is empty or gives up its last slot now.
   assign req_stall = (cnt_ff != 2'd0) && !(head_take && (cnt_ff == 2'd1));
   assign accept    = req_valid && !req_stall;

   assign head.valid = (cnt_ff != 2'd0);
   assign head.slot  = slot_ff[0];

   // Logical index for each possible result position, each saturating on its own.
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         lidx[k] = (lcnt_ff >= lsf_pkg::CNT_CAP - lsf_pkg::CNT_W'(k)) ? lsf_pkg::CNT_CAP
                   : lcnt_ff + lsf_pkg::CNT_W'(k);
      end
   end

   assign held_next = lsf_pkg::sat_inc(held_ff);

   // Splice decision for one byte, then the end-of-stream flush.
   always_comb begin
      for (int k = 0; k < lsf_pkg::SLOTS; k++) begin
         slot_in[k] = '0;
      end
      cnt_in  = 3'd0;
      pend_in = lsf_pkg::PEND_NONE;
      held_in = held_ff;
      phys_in = lsf_pkg::sat_inc(phys_ff);

      // A held backslash, or backslash and CR, that is not a splice goes out first.
      unique case (pend_ff)
         lsf_pkg::PEND_BSL: begin
            if ((req_in_byte != lsf_pkg::CHAR_LF) && (req_in_byte != lsf_pkg::CHAR_CR)) begin
               slot_in[cnt_in[1:0]] = make_slot(lsf_pkg::CHAR_BSL, held_ff, lidx[cnt_in[1:0]]);
               cnt_in = cnt_in + 3'd1;
            end
         end
         lsf_pkg::PEND_BSL_CR: begin
            if (req_in_byte != lsf_pkg::CHAR_LF) begin
               slot_in[cnt_in[1:0]] = make_slot(lsf_pkg::CHAR_BSL, held_ff, lidx[cnt_in[1:0]]);
               cnt_in = cnt_in + 3'd1;
               slot_in[cnt_in[1:0]] = make_slot(lsf_pkg::CHAR_CR, held_next,
                                                lidx[cnt_in[1:0]]);
               cnt_in = cnt_in + 3'd1;
            end
         end
         default: begin
         end
      endcase

      // The new byte itself.
      if ((pend_ff == lsf_pkg::PEND_BSL) && (req_in_byte == lsf_pkg::CHAR_CR)) begin
         pend_in = lsf_pkg::PEND_BSL_CR;
      end else if ((pend_ff != lsf_pkg::PEND_NONE) && (req_in_byte == lsf_pkg::CHAR_LF)) begin
         pend_in = lsf_pkg::PEND_NONE;
      end else if (req_in_byte == lsf_pkg::CHAR_BSL) begin
         pend_in = lsf_pkg::PEND_BSL;
         held_in = phys_ff;
      end else begin
         slot_in[cnt_in[1:0]] = make_slot(req_in_byte, phys_ff, lidx[cnt_in[1:0]]);
         cnt_in = cnt_in + 3'd1;
      end

      lcnt_in = lidx[cnt_in[1:0]];

      // End of stream: flush what is held, mark the last result, start over.
      if (req_in_last) begin
         if (pend_in != lsf_pkg::PEND_NONE) begin
            slot_in[cnt_in[1:0]] = make_slot(lsf_pkg::CHAR_BSL, held_in, lidx[cnt_in[1:0]]);
            cnt_in = cnt_in + 3'd1;
         end
         if (pend_in == lsf_pkg::PEND_BSL_CR) begin
            slot_in[cnt_in[1:0]] = make_slot(lsf_pkg::CHAR_CR, lsf_pkg::sat_inc(held_in),
                                             lidx[cnt_in[1:0]]);
            cnt_in = cnt_in + 3'd1;
         end
         if (cnt_in == 3'd0) begin
            slot_in[0].phys_offset   = phys_in;
            slot_in[0].logical_index = lcnt_ff;
            cnt_in = 3'd1;
         end
         slot_in[2'(cnt_in - 3'd1)].end_of_run = 1'b1;
         pend_in = lsf_pkg::PEND_NONE;
         held_in = '0;
         phys_in = '0;
         lcnt_in = '0;
      end
   end

   // State and bundle registers; the bundle shifts toward the head on each take.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= lsf_pkg::PEND_NONE;
         held_ff <= '0;
         phys_ff <= '0;
         lcnt_ff <= '0;
         cnt_ff  <= 2'd0;
      end else if (accept) begin
         pend_ff <= pend_in;
         held_ff <= held_in;
         phys_ff <= phys_in;
         lcnt_ff <= lcnt_in;
         cnt_ff  <= 2'(cnt_in);
      end else if (head_take) begin
         cnt_ff <= cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int k = 0; k < lsf_pkg::SLOTS; k++) begin
            slot_ff[k] <= slot_in[k];
         end
      end else if (head_take) begin
         for (int k = 0; k < lsf_pkg::SLOTS - 1; k++) begin
            slot_ff[k] <= slot_ff[k+1];
         end
      end
   end

endmodule

>>> rtl/lsf_emit.sv
module lsf_emit (
   input  logic                        clock,
   input  logic                        reset,
   input  lsf_pkg::head_type           head,
   output logic                        head_take,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [7:0]                  rsp_out_char,
   output logic                        rsp_has_char,
   output logic [lsf_pkg::CNT_W-1:0]   rsp_phys_offset,
   output logic [lsf_pkg::CNT_W-1:0]   rsp_logical_index,
   output logic                        rsp_is_space,
   output logic                        rsp_is_digit,
   output logic                        rsp_is_hex,
   output logic                        rsp_is_ident_start,
   output logic                        rsp_is_ident_cont,
   output logic                        rsp_end_of_run
);

   logic                  valid_ff;
   lsf_pkg::slot_type     slot_ff;
   lsf_pkg::class_type    class_ff, class_in;

   // The output register loads when it is empty or its result is taken now.
   assign head_take = head.valid && (!valid_ff || !rsp_stall);
   assign class_in  = lsf_pkg::classify(head.slot.out_char);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (head_take) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (head_take) begin
         slot_ff  <= head.slot;
         class_ff <= class_in;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_out_char       = slot_ff.out_char;
   assign rsp_has_char       = slot_ff.has_char;
   assign rsp_phys_offset    = slot_ff.phys_offset;
   assign rsp_logical_index  = slot_ff.logical_index;
   assign rsp_end_of_run     = slot_ff.end_of_run;
   assign rsp_is_space       = class_ff.is_space;
   assign rsp_is_digit       = class_ff.is_digit;
   assign rsp_is_hex         = class_ff.is_hex;
   assign rsp_is_ident_start = class_ff.is_ident_start;
   assign rsp_is_ident_cont  = class_ff.is_ident_cont;

endmodule

>>> rtl/lsf_checker.sv
module lsf_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [7:0]                  rsp_out_char,
   input logic                        rsp_has_char,
   input logic                        rsp_is_space,
   input logic                        rsp_is_digit,
   input logic                        rsp_is_hex,
   input logic                        rsp_is_ident_start,
   input logic                        rsp_is_ident_cont,
   input logic                        rsp_end_of_run
);

   // No result is shown in the cycle after reset.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result stays valid.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result dropped");

   // The end marker carries no character, no class and closes the stream.
   a_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_char |-> rsp_out_char == 8'h00 && rsp_end_of_run
         && !rsp_is_space && !rsp_is_hex && !rsp_is_ident_cont)
      else $error("malformed end marker");

   // Class flags must agree with each other.
   a_classes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_is_digit || rsp_is_ident_start) |-> rsp_is_ident_cont
         && !rsp_is_space && (!rsp_is_digit || rsp_is_hex))
      else $error("inconsistent class flags");

endmodule

bind line_splice_filter_with_char_class lsf_checker u_lsf_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_out_char       (rsp_out_char),
   .rsp_has_char       (rsp_has_char),
   .rsp_is_space       (rsp_is_space),
   .rsp_is_digit       (rsp_is_digit),
   .rsp_is_hex         (rsp_is_hex),
   .rsp_is_ident_start (rsp_is_ident_start),
   .rsp_is_ident_cont  (rsp_is_ident_cont),
   .rsp_end_of_run     (rsp_end_of_run)
);

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;

   // One source byte as the sender offers it.
   typedef struct {
      logic [7:0] b;
      logic       last;
   } src_byte_type;

   // One logical character, or the bare end marker, as the block reports it.
   typedef struct packed {
      logic [7:0]                ch;
      logic                      has;
      logic [lsf_pkg::CNT_W-1:0] off;
      logic [lsf_pkg::CNT_W-1:0] idx;
      logic                      sp;
      logic                      dg;
      logic                      hx;
      logic                      ids;
      logic                      idc;
      logic                      eor;
   } lchar_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [7:0]                req_in_byte = 8'h00;
   logic                      req_in_last = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [7:0]                rsp_out_char;
   logic                      rsp_has_char;
   logic [lsf_pkg::CNT_W-1:0] rsp_phys_offset;
   logic [lsf_pkg::CNT_W-1:0] rsp_logical_index;
   logic                      rsp_is_space;
   logic                      rsp_is_digit;
   logic                      rsp_is_hex;
   logic                      rsp_is_ident_start;
   logic                      rsp_is_ident_cont;
   logic                      rsp_end_of_run;

   // Source bytes still to be offered and logical characters still expected.
   src_byte_type byte_q[$];
   lchar_type    want_q[$];
   logic [7:0]   stream_buf[$];

   // Splice state of the predictor.
   lsf_pkg::pend_type         pend_st = lsf_pkg::PEND_NONE;
   logic [lsf_pkg::CNT_W-1:0] held_off = '0;
   logic [lsf_pkg::CNT_W-1:0] phys_cnt = '0;
   logic [lsf_pkg::CNT_W-1:0] lchar_cnt = '0;

   // Pacing and bookkeeping.
   int   n_items = 0;
   int   n_streams = 0;
   int   n_taken = 0;
   int   n_results = 0;
   int   n_markers = 0;
   int   n_bad = 0;
   int   tx_gap = 0;
   int   rx_gap = 0;
   int   hold_left = 0;
   int   idle_pct = 0;
   int   phase_cnt = 0;
   logic hold_done = 1'b0;
   logic calm = 1'b0;

   line_splice_filter_with_char_class i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_in_byte        (req_in_byte),
      .req_in_last        (req_in_last),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_char       (rsp_out_char),
      .rsp_has_char       (rsp_has_char),
      .rsp_phys_offset    (rsp_phys_offset),
      .rsp_logical_index  (rsp_logical_index),
      .rsp_is_space       (rsp_is_space),
      .rsp_is_digit       (rsp_is_digit),
      .rsp_is_hex         (rsp_is_hex),
      .rsp_is_ident_start (rsp_is_ident_start),
      .rsp_is_ident_cont  (rsp_is_ident_cont),
      .rsp_end_of_run     (rsp_end_of_run)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Counters stop at the cap instead of wrapping.
   function automatic logic [lsf_pkg::CNT_W-1:0] cap_inc(input logic [lsf_pkg::CNT_W-1:0] v);
      return (v >= lsf_pkg::CNT_CAP) ? lsf_pkg::CNT_CAP : v + lsf_pkg::CNT_W'(1);
   endfunction

   function automatic string fmt_lchar(input lchar_type t);
      return $sformatf("char=%h has=%b off=%0d idx=%0d sp/dg/hx/ids/idc=%b%b%b%b%b eor=%b",
                       t.ch, t.has, t.off, t.idx, t.sp, t.dg, t.hx, t.ids, t.idc, t.eor);
   endfunction

   // Queue one logical character with its class flags and advance the index.
   task automatic emit_char(input logic [7:0] c, input logic [lsf_pkg::CNT_W-1:0] off,
                            inout int n);
      lchar_type t;
      logic      digit;
      logic      alpha;
      digit = (c >= "0") && (c <= "9");
      alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"))
              || (c == lsf_pkg::CHAR_US);
      t     = '0;
      t.ch  = c;
      t.has = 1'b1;
      t.off = off;
      t.idx = lchar_cnt;
      t.sp  = (c == lsf_pkg::CHAR_SP) || (c == lsf_pkg::CHAR_TAB) || (c == lsf_pkg::CHAR_VT)
              || (c == lsf_pkg::CHAR_FF) || (c == lsf_pkg::CHAR_CR);
      t.dg  = digit;
      t.hx  = digit || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
      t.ids = alpha;
      t.idc = alpha || digit;
      want_q.push_back(t);
      lchar_cnt = cap_inc(lchar_cnt);
      n++;
   endtask

   // A byte seen with nothing held: a backslash is held, anything else passes.
   task automatic take_plain(input logic [7:0] b, input logic [lsf_pkg::CNT_W-1:0] p,
                             inout int n);
      if (b == lsf_pkg::CHAR_BSL) begin
         pend_st  = lsf_pkg::PEND_BSL;
         held_off = p;
      end else begin
         pend_st = lsf_pkg::PEND_NONE;
         emit_char(b, p, n);
      end
   endtask

   // Work out the logical characters that one accepted source byte causes.
   task automatic splice_predict(input logic [7:0] b, input logic last);
      int                        n;
      logic [lsf_pkg::CNT_W-1:0] p;
      lchar_type                 t;
      n = 0;
      p = phys_cnt;
      case (pend_st)
         lsf_pkg::PEND_BSL: begin
            if (b == lsf_pkg::CHAR_LF) begin
               pend_st = lsf_pkg::PEND_NONE;
            end else if (b == lsf_pkg::CHAR_CR) begin
               pend_st = lsf_pkg::PEND_BSL_CR;
            end else begin
               emit_char(lsf_pkg::CHAR_BSL, held_off, n);
               take_plain(b, p, n);
            end
         end
         lsf_pkg::PEND_BSL_CR: begin
            if (b == lsf_pkg::CHAR_LF) begin
               pend_st = lsf_pkg::PEND_NONE;
            end else begin
               emit_char(lsf_pkg::CHAR_BSL, held_off, n);
               emit_char(lsf_pkg::CHAR_CR, cap_inc(held_off), n);
               take_plain(b, p, n);
            end
         end
         default: begin
            take_plain(b, p, n);
         end
      endcase
      phys_cnt = cap_inc(phys_cnt);

      // End of stream: flush held bytes, or report a bare marker, then start over.
      if (last) begin
         if (pend_st == lsf_pkg::PEND_BSL) begin
            emit_char(lsf_pkg::CHAR_BSL, held_off, n);
         end else if (pend_st == lsf_pkg::PEND_BSL_CR) begin
            emit_char(lsf_pkg::CHAR_BSL, held_off, n);
            emit_char(lsf_pkg::CHAR_CR, cap_inc(held_off), n);
         end
         if (n == 0) begin
            t     = '0;
            t.off = phys_cnt;
            t.idx = lchar_cnt;
            want_q.push_back(t);
         end
         t     = want_q.pop_back();
         t.eor = 1'b1;
         want_q.push_back(t);
         pend_st   = lsf_pkg::PEND_NONE;
         held_off  = '0;
         phys_cnt  = '0;
         lchar_cnt = '0;
      end
   endtask

   // Move the collected stream into the request queue, the final byte flagged.
   task automatic flush_stream();
      src_byte_type s;
      for (int i = 0; i < stream_buf.size(); i++) begin
         s.b    = stream_buf[i];
         s.last = (i == stream_buf.size() - 1);
         byte_q.push_back(s);
         n_items++;
      end
      n_streams++;
      stream_buf.delete();
   endtask

   // A byte weighted toward the characters the splice logic and classifier care about.
   function automatic logic [7:0] pick_byte();
      logic [7:0] c;
      case ($urandom_range(0, 9))
         0, 1:    c = lsf_pkg::CHAR_BSL;
         2:       c = lsf_pkg::CHAR_LF;
         3:       c = lsf_pkg::CHAR_CR;
         4:       c = 8'h30 + 8'($urandom_range(0, 9));
         5:       c = ($urandom_range(0, 1) != 0) ? 8'h61 + 8'($urandom_range(0, 25))
                                                   : 8'h41 + 8'($urandom_range(0, 25));
         6: begin
            case ($urandom_range(0, 4))
               0:       c = lsf_pkg::CHAR_US;
               1:       c = lsf_pkg::CHAR_SP;
               2:       c = lsf_pkg::CHAR_TAB;
               3:       c = lsf_pkg::CHAR_VT;
               default: c = lsf_pkg::CHAR_FF;
            endcase
         end
         default: c = 8'($urandom_range(0, 255));
      endcase
      return c;
   endfunction

   // Build a stream mostly out of splices, near-splices and ordinary text.
   task automatic add_random_stream();
      int ntok;
      ntok = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
      repeat (ntok) begin
         case ($urandom_range(0, 9))
            0: begin
               stream_buf.push_back(lsf_pkg::CHAR_BSL);
               stream_buf.push_back(lsf_pkg::CHAR_LF);
            end
            1: begin
               stream_buf.push_back(lsf_pkg::CHAR_BSL);
               stream_buf.push_back(lsf_pkg::CHAR_CR);
               stream_buf.push_back(lsf_pkg::CHAR_LF);
            end
            2: begin
               repeat ($urandom_range(2, 4)) begin
                  stream_buf.push_back(lsf_pkg::CHAR_BSL);
                  if ($urandom_range(0, 1) != 0) stream_buf.push_back(lsf_pkg::CHAR_CR);
                  stream_buf.push_back(lsf_pkg::CHAR_LF);
               end
            end
            3: begin
               stream_buf.push_back(lsf_pkg::CHAR_BSL);
               stream_buf.push_back(lsf_pkg::CHAR_CR);
               stream_buf.push_back(pick_byte());
            end
            4: begin
               stream_buf.push_back(lsf_pkg::CHAR_BSL);
               stream_buf.push_back(pick_byte());
            end
            default: begin
               stream_buf.push_back(pick_byte());
            end
         endcase
      end
      // Sometimes leave a backslash, or a backslash and CR, hanging at the end.
      case ($urandom_range(0, 5))
         0: stream_buf.push_back(lsf_pkg::CHAR_BSL);
         1: begin
            stream_buf.push_back(lsf_pkg::CHAR_BSL);
            stream_buf.push_back(lsf_pkg::CHAR_CR);
         end
         default: ;
      endcase
      flush_stream();
   endtask

   // Request driver: offers queued bytes, with random gaps away from the end.
   always @(posedge clock) begin
      src_byte_type nxt;
      if (reset) begin
         req_valid   <= 1'b0;
         req_in_byte <= 8'h00;
         req_in_last <= 1'b0;
         tx_gap      <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            splice_predict(req_in_byte, req_in_last);
            n_taken <= n_taken + 1;
         end
         calm <= (byte_q.size() < 25);
         if (!req_valid || !req_stall) begin
            if (tx_gap != 0) begin
               tx_gap    <= tx_gap - 1;
               req_valid <= 1'b0;
            end else if (byte_q.size() != 0) begin
               nxt = byte_q.pop_front();
               req_valid   <= 1'b1;
               req_in_byte <= nxt.b;
               req_in_last <= nxt.last;
               if (!calm && ($urandom_range(0, 99) < idle_pct)) begin
                  tx_gap <= $urandom_range(1, 5);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: checks each accepted result and paces the receiver's stall.
   always @(posedge clock) begin
      lchar_type got;
      lchar_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         rx_gap    <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.ch  = rsp_out_char;
            got.has = rsp_has_char;
            got.off = rsp_phys_offset;
            got.idx = rsp_logical_index;
            got.sp  = rsp_is_space;
            got.dg  = rsp_is_digit;
            got.hx  = rsp_is_hex;
            got.ids = rsp_is_ident_start;
            got.idc = rsp_is_ident_cont;
            got.eor = rsp_end_of_run;
            n_results++;
            if (!got.has) n_markers++;
            if (want_q.size() == 0) begin
               n_bad++;
               if (n_bad <= 10) $display("unexpected result: %s", fmt_lchar(got));
            end else begin
               want = want_q.pop_front();
               if (got != want) begin
                  n_bad++;
                  if (n_bad <= 10) begin
                     $display("mismatch at result %0d", n_results);
                     $display("  expected %s", fmt_lchar(want));
                     $display("  actual   %s", fmt_lchar(got));
                  end
               end
            end
         end
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
         end else if (rx_gap != 0) begin
            rsp_stall <= 1'b1;
            rx_gap    <= rx_gap - 1;
         end else if (!calm && ($urandom_range(0, 99) < idle_pct)) begin
            rsp_stall <= 1'b1;
            rx_gap    <= $urandom_range(0, 4);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Idle rate changes by phase; one long receiver hold-off fills the block.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
         idle_pct  <= 0;
         phase_cnt <= 0;
      end else begin
         phase_cnt <= phase_cnt + 1;
         if (phase_cnt % 40 == 0) begin
            case ($urandom_range(0, 2))
               0:       idle_pct <= 0;
               1:       idle_pct <= 15;
               default: idle_pct <= 40;
            endcase
         end
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
         end else if (!hold_done && (n_taken >= 60)) begin
            hold_left <= 50;
            hold_done <= 1'b1;
         end
      end
   end

   // Stimulus, reset and end of run.
   initial begin
      // Single plain character.
      stream_buf = '{8'h41};
      flush_stream();
      // Lone backslash flushed at the end.
      stream_buf = '{lsf_pkg::CHAR_BSL};
      flush_stream();
      // Backslash and CR flushed at the end.
      stream_buf = '{lsf_pkg::CHAR_BSL, lsf_pkg::CHAR_CR};
      flush_stream();
      // A stream that is only a splice leaves a bare end marker.
      stream_buf = '{lsf_pkg::CHAR_BSL, lsf_pkg::CHAR_LF};
      flush_stream();
      // Backslash after a held backslash.
      stream_buf = '{lsf_pkg::CHAR_BSL, lsf_pkg::CHAR_BSL, 8'h47};
      flush_stream();
      // Backslash and CR not followed by LF, three results from one byte.
      stream_buf = '{lsf_pkg::CHAR_BSL, lsf_pkg::CHAR_CR, 8'h5A};
      flush_stream();
      stream_buf = '{lsf_pkg::CHAR_BSL, lsf_pkg::CHAR_CR, lsf_pkg::CHAR_BSL};
      flush_stream();
      // Chain of both splice forms.
      stream_buf = '{lsf_pkg::CHAR_BSL, lsf_pkg::CHAR_LF, lsf_pkg::CHAR_BSL,
                     lsf_pkg::CHAR_CR, lsf_pkg::CHAR_LF, 8'h30};
      flush_stream();
      // NUL, top byte value and class edges.
      stream_buf = '{8'h00, 8'hFF, lsf_pkg::CHAR_US, 8'h66};
      flush_stream();

      while (n_items < 210) add_random_stream();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while ((n_taken != n_items) || (want_q.size() != 0)) @(negedge clock);
      repeat (20) @(negedge clock);

      $display("Covered %0d source bytes in %0d streams with splices, chains and flushes.",
               n_items, n_streams);
      $display("Checked %0d results, %0d of them bare end markers; %0d mismatches.",
               n_results, n_markers, n_bad);
      if ((n_bad == 0) && (want_q.size() == 0)) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #200000;
      $display("timeout with %0d of %0d bytes taken and %0d results pending",
               n_taken, n_items, want_q.size());
      $display("CHECK FAILED");
      $finish;
   end

endmodule
